// File: rtl/wtdf_pkg.sv
// Package with shared types and constants of the trial-division factorizer.
`default_nettype none
package wtdf_pkg;
   localparam int N_BITS_DEFAULT = 32;
   localparam int FACTOR_BITS = 32;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_BITS = 6;

   typedef struct packed {
      logic load;
      logic div_start;
      logic take_quot;
      logic next_div;
      logic next_small;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rem_zero;
      logic quot_one;
      logic small_phase;
      logic sq_gt;
   } dp_stat_type;

   function automatic logic [2:0] wheel_gap(input logic [2:0] phase);
      logic [2:0] g;
      case (phase)
         3'd0: g = 3'd4;
         3'd1: g = 3'd2;
         3'd2: g = 3'd4;
         3'd3: g = 3'd2;
         3'd4: g = 3'd4;
         3'd5: g = 3'd6;
         3'd6: g = 3'd2;
         default: g = 3'd6;
      endcase
      return g;
   endfunction
endpackage
`default_nettype wire

// File: rtl/wtdf_datapath.sv
// Datapath: remainder, trial divisor, wheel phase and a bit-serial divider.
`default_nettype none
module wtdf_datapath #(
   parameter int N_BITS = wtdf_pkg::N_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [N_BITS-1:0]   number,
   input  wire wtdf_pkg::dp_cmd_type cmd,
   output wtdf_pkg::dp_stat_type    stat,
   output logic [N_BITS-1:0]        rem_value,
   output logic [N_BITS-1:0]        div_value
);
   localparam int CB = $clog2(N_BITS + 1);

   logic [N_BITS-1:0] rem_ff, rem_in;
   logic [N_BITS-1:0] dvs_ff, dvs_in;
   logic [2:0]        phase_ff, phase_in;
   logic [1:0]        small_ff, small_in;
   logic [N_BITS-1:0] quot_ff, quot_in;
   logic [N_BITS:0]   part_ff, part_in;
   logic [CB-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [N_BITS:0]   shifted, diff;

   always_comb begin
      shifted = {part_ff[N_BITS-1:0], quot_ff[N_BITS-1]};
      diff = shifted - {1'b0, dvs_ff};
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      phase_in = phase_ff;
      small_in = small_ff;
      quot_in = quot_ff;
      part_in = part_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (cmd.load) begin
         rem_in = number;
         dvs_in = N_BITS'(2);
         phase_in = '0;
         small_in = '0;
      end
      if (cmd.take_quot) rem_in = quot_ff;
      if (cmd.next_small) begin
         small_in = small_ff + 2'd1;
         dvs_in = (small_ff == 2'd0) ? N_BITS'(3) :
                  (small_ff == 2'd1) ? N_BITS'(5) : N_BITS'(7);
      end
      if (cmd.next_div) begin
         dvs_in = dvs_ff + N_BITS'(wtdf_pkg::wheel_gap(phase_ff));
         phase_in = phase_ff + 3'd1;
      end
      if (cmd.div_start) begin
         quot_in = rem_ff;
         part_in = '0;
         cnt_in = CB'(N_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[N_BITS]) begin
            part_in = diff;
            quot_in = {quot_ff[N_BITS-2:0], 1'b1};
         end else begin
            part_in = shifted;
            quot_in = {quot_ff[N_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         small_ff <= '0;
         phase_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         small_ff <= small_in;
         phase_ff <= phase_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quot_ff <= quot_in;
      part_ff <= part_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      stat.div_done = done_ff;
      stat.rem_zero = (part_ff == '0);
      stat.quot_one = (quot_ff == N_BITS'(1));
      stat.small_phase = (small_ff != 2'd3);
      stat.sq_gt = (quot_ff < dvs_ff);
   end
   assign rem_value = rem_ff;
   assign div_value = dvs_ff;
endmodule
`default_nettype wire

// File: rtl/wtdf_control.sv
// Controller state machine that sequences trials and emits result beats.
`default_nettype none
module wtdf_control #(
   parameter int N_BITS = wtdf_pkg::N_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [N_BITS-1:0]    req_number,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [wtdf_pkg::FACTOR_BITS-1:0] rsp_factor,
   output logic                      rsp_last,
   output logic                      rsp_bad_input,
   output wtdf_pkg::dp_cmd_type      cmd,
   input  wire wtdf_pkg::dp_stat_type stat,
   input  wire logic [N_BITS-1:0]    rem_value,
   input  wire logic [N_BITS-1:0]    div_value
);
   typedef enum logic [2:0] {
      S_IDLE, S_START, S_WAIT, S_DECIDE, S_OUT, S_FINAL
   } state_type;

   state_type state_ff;
   logic      valid_ff;
   logic [wtdf_pkg::FACTOR_BITS-1:0] factor_ff;
   logic      last_ff, bad_ff;
   logic [wtdf_pkg::CNT_BITS-1:0] cnt_ff;
   logic      free;
   logic      emit;

   assign free = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !free;
   assign emit = free && (((state_ff == S_IDLE) && req_valid &&
                           (req_number <= N_BITS'(1))) ||
                          (state_ff == S_OUT) || (state_ff == S_FINAL));

   always_comb begin
      cmd = '0;
      cmd.load = (state_ff == S_IDLE) && req_valid && !req_stall &&
                 (req_number > N_BITS'(1));
      cmd.div_start = (state_ff == S_START);
      cmd.take_quot = (state_ff == S_OUT) && free;
      cmd.next_small = (state_ff == S_DECIDE) && !stat.rem_zero && stat.small_phase;
      cmd.next_div = (state_ff == S_DECIDE) && !stat.rem_zero && !stat.small_phase &&
                     !stat.sq_gt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (emit) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && !req_stall) begin
               cnt_ff <= '0;
               if (req_number <= N_BITS'(1)) begin
                  factor_ff <= wtdf_pkg::FACTOR_BITS'(req_number);
                  last_ff <= 1'b1;
                  bad_ff <= (req_number == '0);
               end else begin
                  state_ff <= S_START;
               end
            end
            S_START: state_ff <= S_WAIT;
            S_WAIT: if (stat.div_done) state_ff <= S_DECIDE;
            S_DECIDE: begin
               if (stat.rem_zero) begin
                  if (cnt_ff == wtdf_pkg::CNT_BITS'(wtdf_pkg::MAX_RESULTS - 1))
                     state_ff <= S_FINAL;
                  else
                     state_ff <= S_OUT;
               end else if (stat.small_phase) begin
                  state_ff <= S_START;
               end else if (stat.sq_gt) begin
                  state_ff <= S_FINAL;
               end else begin
                  state_ff <= S_START;
               end
            end
            S_OUT: if (free) begin
               factor_ff <= wtdf_pkg::FACTOR_BITS'(div_value);
               bad_ff <= 1'b0;
               cnt_ff <= cnt_ff + wtdf_pkg::CNT_BITS'(1);
               last_ff <= stat.quot_one;
               state_ff <= stat.quot_one ? S_IDLE : S_START;
            end
            S_FINAL: if (free) begin
               factor_ff <= wtdf_pkg::FACTOR_BITS'(rem_value);
               bad_ff <= 1'b0;
               last_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_factor = factor_ff;
   assign rsp_last = last_ff;
   assign rsp_bad_input = bad_ff;
endmodule
`default_nettype wire

// File: rtl/wheel_trial_division_factorizer.sv
// Top level of the mod-30 wheel trial-division factorizer.
// Usage: present a number on req_number with req_valid; it is taken at an
// edge where req_stall is low. The block returns the prime factors in
// ascending order, one beat each on rsp_factor, with rsp_last on the final
// beat. Zero returns one beat with rsp_bad_input set; one returns factor 1.
// Each trial runs a division in the bit-serial divider. One number is
// factored at a time; req_stall is high until the last beat is
// registered and while a result beat waits. Reset is synchronous and
// returns the block to idle with no result pending. A stalled result
// beat holds; trials go on, but the next beat waits until it is taken.
`default_nettype none
module wheel_trial_division_factorizer #(
   parameter int N_BITS = wtdf_pkg::N_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [N_BITS-1:0] req_number,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [wtdf_pkg::FACTOR_BITS-1:0] rsp_factor,
   output logic                   rsp_last,
   output logic                   rsp_bad_input
);
   wtdf_pkg::dp_cmd_type  cmd;
   wtdf_pkg::dp_stat_type stat;
   logic [N_BITS-1:0] rem_value, div_value;

   wtdf_datapath #(.N_BITS(N_BITS)) u_dp (
      .clock(clock), .reset(reset), .number(req_number), .cmd(cmd),
      .stat(stat), .rem_value(rem_value), .div_value(div_value)
   );

   wtdf_control #(.N_BITS(N_BITS)) u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .req_number(req_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_factor(rsp_factor), .rsp_last(rsp_last),
      .rsp_bad_input(rsp_bad_input), .cmd(cmd), .stat(stat),
      .rem_value(rem_value), .div_value(div_value)
   );
endmodule
`default_nettype wire

// File: rtl/wtdf_checker.sv
// Port checker for the factorizer, bound to the top level.
`default_nettype none
module wtdf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_last,
   input wire logic rsp_bad_input,
   input wire logic [31:0] rsp_factor
);
   a_bad_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_input |-> rsp_last && rsp_factor == '0)
      else $error("bad input beat malformed");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_factor))
      else $error("stalled beat changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_bad_input |=> req_stall || rsp_valid)
      else $error("accept not followed by work");
endmodule
bind wheel_trial_division_factorizer wtdf_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_last(rsp_last),
   .rsp_bad_input(rsp_bad_input), .rsp_factor(rsp_factor)
);
`default_nettype wire
